/* rtl/text_console_writer_macros.svh */
// ----------------------------------------------------------------------------
// Text console writer assertion macros
// Clocked, reset-qualified concurrent assertion shorthands.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_MACROS_SVH
`define TEXT_CONSOLE_WRITER_MACROS_SVH

`ifndef SYNTH

// Hold a condition at every clock edge out of reset.
`define TCW_ASSERT(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Require cons in the same cycle whenever ante holds.
`define TCW_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Require cons in the cycle after ante.
`define TCW_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define TCW_ASSERT(label, expr, msg)
`define TCW_ASSERT_IMPL(label, ante, cons, msg)
`define TCW_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

/* rtl/tcw_pkg.sv */
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared geometry, codes, types and address helpers of the text console.
// ----------------------------------------------------------------------------
package tcw_pkg;

	localparam int COLUMNS  = 80;
	localparam int ROWS     = 25;
	localparam int TAB_STOP = 8;     // power of two
	localparam int CELLS    = ROWS * COLUMNS;
	localparam int ADDR_W   = $clog2(CELLS);

	localparam int COL_W     = 7;
	localparam int ROW_W     = 5;
	localparam int CHAR_W    = 8;
	localparam int CELL_W    = 16;
	localparam int CLR_W     = 4;
	localparam int CFG_IDX_W = 1;

	localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
	localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
	localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;
	localparam logic [CHAR_W-1:0] RESET_ATTR   = 8'h0F;

	localparam logic [CLR_W-1:0] RESET_FG = 4'hF;
	localparam logic [CLR_W-1:0] RESET_BG = 4'h0;

	localparam logic [CFG_IDX_W-1:0] CFG_FG_COLOR = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_BG_COLOR = 1'b1;

	typedef enum logic [1:0] {
		FUNC_PUT   = 2'd0,
		FUNC_CLEAR = 2'd1,
		FUNC_READ  = 2'd2,
		FUNC_NONE  = 2'd3
	} func_t;

	// Result of one put-character cursor step.
	typedef struct packed {
		logic [COL_W-1:0] col;       // cursor column after the step
		logic [ROW_W-1:0] row;       // cursor row after the step (clamped on scroll)
		logic             scroll;    // step ran past the last row
		logic             wr_en;     // a cell is written on the cursor row
		logic             wr_blank;  // written cell is a blank, not the character
		logic [COL_W-1:0] wr_col;    // column of the written cell
	} cur_step_t;

	// Map a logical row onto its physical row of the circular screen buffer.
	function automatic logic [ROW_W-1:0] phys_row(
		input logic [ROW_W-1:0] row,
		input logic [ROW_W-1:0] top
	);
		logic [ROW_W:0] sum;
		sum = {1'b0, row} + {1'b0, top};
		if (sum >= (ROW_W+1)'(ROWS)) begin
			sum = sum - (ROW_W+1)'(ROWS);
		end
		return sum[ROW_W-1:0];
	endfunction

	function automatic logic [ADDR_W-1:0] cell_addr(
		input logic [ROW_W-1:0] prow,
		input logic [COL_W-1:0] col
	);
		return ADDR_W'(prow) * ADDR_W'(COLUMNS) + ADDR_W'(col);
	endfunction

endpackage

/* rtl/tcw_ram.sv */
// ----------------------------------------------------------------------------
// tcw_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* rtl/tcw_cursor.sv */
// ----------------------------------------------------------------------------
// tcw_cursor
// Cursor step for one put character: control bytes, line wrap, scroll flag.
// ----------------------------------------------------------------------------
module tcw_cursor import tcw_pkg::*; (
	input  logic [CHAR_W-1:0] char_code,
	input  logic [COL_W-1:0]  cur_col,
	input  logic [ROW_W-1:0]  cur_row,
	output cur_step_t         step
);

	logic [COL_W:0]   nx;
	logic [ROW_W:0]   ny;
	logic [COL_W-1:0] bs_col;

	always_comb begin
		bs_col        = (cur_col != '0) ? cur_col - COL_W'(1) : '0;
		nx            = {1'b0, cur_col};
		ny            = {1'b0, cur_row};
		step.wr_en    = 1'b0;
		step.wr_blank = 1'b0;
		step.wr_col   = cur_col;

		priority if (char_code == CH_NEWLINE) begin
			nx = '0;
			ny = ny + (ROW_W+1)'(1);
		end else if (char_code == CH_RETURN) begin
			nx = '0;
		end else if (char_code == CH_TAB) begin
			nx = (nx & ~(COL_W+1)'(TAB_STOP - 1)) + (COL_W+1)'(TAB_STOP);
		end else if (char_code == CH_BACKSPACE) begin
			// step back unless at column 0, blank the cell under the cursor
			nx            = {1'b0, bs_col};
			step.wr_en    = 1'b1;
			step.wr_blank = 1'b1;
			step.wr_col   = bs_col;
		end else begin
			step.wr_en = 1'b1;
			nx         = nx + (COL_W+1)'(1);
		end

		if (nx >= (COL_W+1)'(COLUMNS)) begin
			nx = '0;
			ny = ny + (ROW_W+1)'(1);
		end

		step.scroll = (ny >= (ROW_W+1)'(ROWS));
		step.col    = nx[COL_W-1:0];
		step.row    = step.scroll ? ROW_W'(ROWS - 1) : ny[ROW_W-1:0];
	end

endmodule

/* rtl/text_console_writer.sv */
// ----------------------------------------------------------------------------
// text_console_writer
// Item flow: an accepted put or none item passes EXEC, then FINISH; a read
//   passes READ between them. A scroll blanks the COLUMNS (80) cells of the new
//   bottom row and a clear all ROWS*COLUMNS (2000) cells in SWEEP before FINISH,
//   one cell per cycle through the single screen RAM write port. One item at a
//   time: in_ready returns with the result; FINISH waits for a free output register.
// Reset: cursor homes, colors reset, then a clearing pass writes 0x0F20 to
//   every cell with in_ready low; config writes are taken meanwhile.
// ----------------------------------------------------------------------------
`include "text_console_writer_macros.svh"

module text_console_writer import tcw_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,

	// configuration
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CLR_W-1:0]     cfg_data,

	// input items
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           func,
	input  logic [CHAR_W-1:0]    char_code,
	input  logic [ROW_W-1:0]     read_row,
	input  logic [COL_W-1:0]     read_col,

	// result items
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [CELL_W-1:0]    cell_data,
	output logic [COL_W-1:0]     cursor_col,
	output logic [ROW_W-1:0]     cursor_row,
	output logic                 scrolled
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_READ,
		ST_SWEEP,
		ST_FINISH
	} state_t;

	state_t state_q;

	// colors
	logic [CLR_W-1:0] fg_q;
	logic [CLR_W-1:0] bg_q;

	// cursor and circular row origin: logical row 0 lives at physical row top_q
	logic [COL_W-1:0] cur_col_q;
	logic [ROW_W-1:0] cur_row_q;
	logic [ROW_W-1:0] top_q;

	// captured item
	func_t             func_q;
	logic [CHAR_W-1:0] char_q;
	logic [ROW_W-1:0]  rd_row_q;
	logic [COL_W-1:0]  rd_col_q;

	// per-item results before the output register
	logic [CELL_W-1:0] data_q;
	logic              scrolled_q;

	// blanking sweep
	logic [ADDR_W-1:0] sweep_addr_q;
	logic [ADDR_W-1:0] sweep_last_q;
	logic [CELL_W-1:0] sweep_data_q;
	logic              sweep_report_q;   // finish with a result (not the reset pass)

	// output register
	logic              out_valid_q;
	logic [CELL_W-1:0] out_data_q;
	logic [COL_W-1:0]  out_col_q;
	logic [ROW_W-1:0]  out_row_q;
	logic              out_scrolled_q;

	// datapath
	cur_step_t         step;
	logic [CHAR_W-1:0] attr;
	logic [CELL_W-1:0] blank_cell;
	logic              rd_in_range;
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [CELL_W-1:0] ram_wdata;
	logic              ram_re;
	logic [ADDR_W-1:0] ram_raddr;
	logic [CELL_W-1:0] ram_rdata;
	logic              out_free;

	tcw_cursor u_cursor (
		.char_code (char_q),
		.cur_col   (cur_col_q),
		.cur_row   (cur_row_q),
		.step      (step)
	);

	tcw_ram #(
		.WIDTH (CELL_W),
		.DEPTH (CELLS)
	) u_screen (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign attr        = {bg_q, fg_q};
	assign blank_cell  = {attr, BLANK_CHAR};
	assign rd_in_range = (rd_row_q < ROW_W'(ROWS)) && (rd_col_q < COL_W'(COLUMNS));
	assign out_free    = !out_valid_q || out_ready;
	assign in_ready    = (state_q == ST_IDLE);

	// RAM port steering: the sweep owns the write port, otherwise a put writes
	// its cell during EXEC; reads issue in EXEC and return in READ.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cell_addr(phys_row(cur_row_q, top_q), step.wr_col);
		ram_wdata = step.wr_blank ? blank_cell : {attr, char_q};
		ram_re    = (state_q == ST_EXEC) && (func_q == FUNC_READ) && rd_in_range;
		ram_raddr = cell_addr(phys_row(rd_row_q, top_q), rd_col_q);
		if (state_q == ST_SWEEP) begin
			ram_we    = 1'b1;
			ram_waddr = sweep_addr_q;
			ram_wdata = sweep_data_q;
		end else if (state_q == ST_EXEC && func_q == FUNC_PUT) begin
			ram_we = step.wr_en;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_SWEEP;
			fg_q           <= RESET_FG;
			bg_q           <= RESET_BG;
			cur_col_q      <= '0;
			cur_row_q      <= '0;
			top_q          <= '0;
			func_q         <= FUNC_NONE;
			char_q         <= '0;
			rd_row_q       <= '0;
			rd_col_q       <= '0;
			data_q         <= '0;
			scrolled_q     <= 1'b0;
			sweep_addr_q   <= '0;
			sweep_last_q   <= ADDR_W'(CELLS - 1);
			sweep_data_q   <= {RESET_ATTR, BLANK_CHAR};
			sweep_report_q <= 1'b0;
			out_valid_q    <= 1'b0;
			out_data_q     <= '0;
			out_col_q      <= '0;
			out_row_q      <= '0;
			out_scrolled_q <= 1'b0;
		end else begin
			// configuration writes land at any time
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_FG_COLOR: fg_q <= cfg_data;
					CFG_BG_COLOR: bg_q <= cfg_data;
				endcase
			end

			// drop the result once taken; FINISH reloads the register itself
			if (out_valid_q && out_ready && state_q != ST_FINISH) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						func_q     <= func_t'(func);
						char_q     <= char_code;
						rd_row_q   <= read_row;
						rd_col_q   <= read_col;
						data_q     <= '0;
						scrolled_q <= 1'b0;
						state_q    <= ST_EXEC;
					end
				end

				ST_EXEC: begin
					unique case (func_q)
						FUNC_PUT: begin
							cur_col_q <= step.col;
							cur_row_q <= step.row;
							if (step.scroll) begin
								// advance the origin; the old top row becomes the
								// new bottom row and is blanked in place
								scrolled_q     <= 1'b1;
								top_q          <= phys_row(ROW_W'(1), top_q);
								sweep_addr_q   <= cell_addr(top_q, '0);
								sweep_last_q   <= cell_addr(top_q, COL_W'(COLUMNS - 1));
								sweep_data_q   <= blank_cell;
								sweep_report_q <= 1'b1;
								state_q        <= ST_SWEEP;
							end else begin
								state_q <= ST_FINISH;
							end
						end
						FUNC_CLEAR: begin
							cur_col_q      <= '0;
							cur_row_q      <= '0;
							top_q          <= '0;
							sweep_addr_q   <= '0;
							sweep_last_q   <= ADDR_W'(CELLS - 1);
							sweep_data_q   <= blank_cell;
							sweep_report_q <= 1'b1;
							state_q        <= ST_SWEEP;
						end
						FUNC_READ: begin
							state_q <= ST_READ;
						end
						FUNC_NONE: begin
							state_q <= ST_FINISH;
						end
					endcase
				end

				ST_READ: begin
					data_q  <= rd_in_range ? ram_rdata : '0;
					state_q <= ST_FINISH;
				end

				ST_SWEEP: begin
					if (sweep_addr_q == sweep_last_q) begin
						state_q <= sweep_report_q ? ST_FINISH : ST_IDLE;
					end else begin
						sweep_addr_q <= sweep_addr_q + ADDR_W'(1);
					end
				end

				ST_FINISH: begin
					// hold until the output register is free
					if (out_free) begin
						out_valid_q    <= 1'b1;
						out_data_q     <= data_q;
						out_col_q      <= cur_col_q;
						out_row_q      <= cur_row_q;
						out_scrolled_q <= scrolled_q;
						state_q        <= ST_IDLE;
					end
				end
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign cell_data  = out_data_q;
	assign cursor_col = out_col_q;
	assign cursor_row = out_row_q;
	assign scrolled   = out_scrolled_q;

	// ------------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------------
	`TCW_ASSERT(a_cursor_row_range, (cur_row_q < ROW_W'(ROWS)) && (top_q < ROW_W'(ROWS)),
		"cursor row or row origin out of range")
	`TCW_ASSERT_IMPL(a_sweep_addr_range, ram_we, ram_waddr < ADDR_W'(CELLS),
		"screen write beyond last cell")
	`TCW_ASSERT_IMPL(a_scroll_bottom_row, out_valid_q && out_scrolled_q,
		out_row_q == ROW_W'(ROWS - 1), "scroll result not on bottom row")
	`TCW_ASSERT_NEXT(a_one_item_at_a_time, in_valid && in_ready, !in_ready,
		"second item accepted while one is in flight")

endmodule
